/* sv/sapi_rx_pkg.sv */
// types and constants shared by the serial-api frame receiver
// no dependencies; used by sapi_rx_core, sapi_rx_obuf and the top level
`timescale 1ns / 1ps

package sapi_rx_pkg;

    // frame marks
    localparam logic [7:0] SOF_MARK   = 8'h01;
    localparam logic [7:0] CHECK_SEED = 8'hFF;

    // input word kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result word kinds
    localparam logic KIND_BODY = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HDR_TMO  = 3'd1;
    localparam logic [2:0] ST_BAD_SOF  = 3'd2;
    localparam logic [2:0] ST_BODY_TMO = 3'd3;
    localparam logic [2:0] ST_BAD_SUM  = 3'd4;

    // reply owed to the sender
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NACK = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] body_byte;
        logic [2:0] frame_status;
        logic [7:0] body_length;
        logic [1:0] reply_code;
    } out_word_t;

endpackage

/* sv/sapi_rx_core.sv */
// frame state machine: header, length, body, checksum and timers
// depends on sapi_rx_pkg
`timescale 1ns / 1ps

module sapi_rx_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  item_valid,
    input  sapi_rx_pkg::in_word_t item,
    output logic                  res_valid,
    output sapi_rx_pkg::out_word_t res
);

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  first_reg,   first_next;
    logic [7:0]  len_reg,     len_next;
    logic [7:0]  left_reg,    left_next;
    logic [7:0]  check_reg,   check_next;
    logic [15:0] ticks_reg,   ticks_next;
    logic [15:0] timeout_reg;
    logic [7:0]  left_dec;
    logic        end_frame;

    function automatic sapi_rx_pkg::out_word_t end_word(
        input logic [2:0] status,
        input logic [7:0] length,
        input logic [1:0] reply
    );
        sapi_rx_pkg::out_word_t w;
        w.result_kind  = sapi_rx_pkg::KIND_END;
        w.body_byte    = 8'd0;
        w.frame_status = status;
        w.body_length  = length;
        w.reply_code   = reply;
        return w;
    endfunction

    assign left_dec = left_reg - 8'd1;

    always_comb begin
        phase_next = phase_reg;
        first_next = first_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        check_next = check_reg;
        ticks_next = ticks_reg;
        res_valid  = 1'b0;
        res        = '0;
        end_frame  = 1'b0;
        if (item_valid) begin
            if (item.req_type == sapi_rx_pkg::REQ_TICK) begin
                if (ticks_reg >= timeout_reg) begin
                    end_frame = 1'b1;
                    if (phase_reg == PH_BODY) begin
                        res = end_word(sapi_rx_pkg::ST_BODY_TMO, 8'd0, sapi_rx_pkg::REPLY_NACK);
                    end else begin
                        res = end_word(sapi_rx_pkg::ST_HDR_TMO, 8'd0, sapi_rx_pkg::REPLY_NONE);
                    end
                end else begin
                    ticks_next = ticks_reg + 16'd1;
                end
            end else begin
                case (phase_reg)
                    PH_LEN: begin
                        if (first_reg != sapi_rx_pkg::SOF_MARK) begin
                            end_frame = 1'b1;
                            res = end_word(sapi_rx_pkg::ST_BAD_SOF, 8'd0, sapi_rx_pkg::REPLY_NONE);
                        end else begin
                            len_next = item.rx_byte;
                            if (item.rx_byte == 8'd0) begin
                                end_frame = 1'b1;
                                res = end_word(sapi_rx_pkg::ST_BAD_SUM, 8'd0,
                                               sapi_rx_pkg::REPLY_NACK);
                            end else begin
                                left_next  = item.rx_byte;
                                check_next = sapi_rx_pkg::CHECK_SEED ^ item.rx_byte;
                                ticks_next = 16'd0;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        left_next = left_dec;
                        if (left_dec != 8'd0) begin
                            check_next        = check_reg ^ item.rx_byte;
                            res.result_kind   = sapi_rx_pkg::KIND_BODY;
                            res.body_byte     = item.rx_byte;
                        end else if (check_reg == item.rx_byte) begin
                            end_frame = 1'b1;
                            res = end_word(sapi_rx_pkg::ST_OK, len_reg - 8'd1,
                                           sapi_rx_pkg::REPLY_ACK);
                        end else begin
                            end_frame = 1'b1;
                            res = end_word(sapi_rx_pkg::ST_BAD_SUM, 8'd0,
                                           sapi_rx_pkg::REPLY_NACK);
                        end
                        res_valid = 1'b1;
                    end
                    default: begin
                        first_next = item.rx_byte;
                        phase_next = PH_LEN;
                    end
                endcase
            end
            if (end_frame) begin
                res_valid  = 1'b1;
                phase_next = PH_HEAD;
                ticks_next = 16'd0;
                left_next  = 8'd0;
                check_next = sapi_rx_pkg::CHECK_SEED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD;
            first_reg   <= 8'd0;
            len_reg     <= 8'd0;
            left_reg    <= 8'd0;
            check_reg   <= sapi_rx_pkg::CHECK_SEED;
            ticks_reg   <= 16'd0;
            timeout_reg <= sapi_rx_pkg::TIMEOUT_RESET;
        end else begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            check_reg <= check_next;
            ticks_reg <= ticks_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

endmodule

/* sv/sapi_rx_obuf.sv */
// two-entry result buffer between the frame logic and the result channel
// depends on sapi_rx_pkg
`timescale 1ns / 1ps

module sapi_rx_obuf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sapi_rx_pkg::out_word_t push_data,
    output logic                   has_room,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sapi_rx_pkg::out_word_t m_data
);

    sapi_rx_pkg::out_word_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign m_valid  = (count_reg != 2'd0);
    assign has_room = (count_reg != 2'd2);
    assign m_data   = entry_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/serial_api_frame_receiver.sv */
// serial-api frame receiver: each result word is registered in the result buffer;
// throughput one input word per cycle while s_ready is high; each word yields zero or one result
// the per-word rate is set by the frame state update in sapi_rx_core
// s_ready drops only while both result buffer entries are waiting to be taken
// reset is synchronous on aresetn low: header phase, timer cleared, timeout 3
// depends on sapi_rx_pkg, sapi_rx_core and sapi_rx_obuf
`timescale 1ns / 1ps

module serial_api_frame_receiver (
    input  logic                   aclk,
    input  logic                   aresetn,
    // timeout register write
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    // received bytes and timer ticks
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sapi_rx_pkg::in_word_t  s_data,
    // body bytes and frame-end words
    output logic                   m_valid,
    input  logic                   m_ready,
    output sapi_rx_pkg::out_word_t m_data
);

    logic                   in_accept;
    logic                   res_valid;
    sapi_rx_pkg::out_word_t res;
    logic                   has_room;

    // a word is taken whenever the buffer can hold the result it may cause
    assign s_ready   = has_room;
    assign in_accept = s_valid && s_ready;

    // frame state machine, one word per cycle while the buffer has room
    sapi_rx_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (in_accept),
        .item        (s_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register with one skid entry
    sapi_rx_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .has_room  (has_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    // a full buffer always has a word on offer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // a result is produced only for an accepted word
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> in_accept)
        else $error("result without accepted input word");

    // body words carry no status or reply
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == sapi_rx_pkg::KIND_BODY) |->
        (m_data.frame_status == sapi_rx_pkg::ST_OK &&
         m_data.reply_code == sapi_rx_pkg::REPLY_NONE))
        else $error("body word with status or reply");

    // a good frame always owes an ack
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == sapi_rx_pkg::KIND_END &&
         m_data.frame_status == sapi_rx_pkg::ST_OK) |->
        (m_data.reply_code == sapi_rx_pkg::REPLY_ACK))
        else $error("good frame without ack");
`endif

endmodule
